// ===== rtl/core/cassette_block_deframer_macros.svh =====
// Assertion macros used by the cassette block deframer core.
`ifndef CASSETTE_BLOCK_DEFRAMER_MACROS_SVH
`define CASSETTE_BLOCK_DEFRAMER_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define CBD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the cycle after.
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cbd_pkg.sv =====
// Package with the types and constants of the cassette block deframer.
`default_nettype none

package cbd_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = $clog2(BYTE_BITS);

    localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(BYTE_BITS - 1);
    localparam logic [7:0]       SYNC_RESET  = 8'h3c;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_TYPE = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_SUM  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] hdr_type;
        logic [7:0] hdr_len;
        logic       checksum_bad;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_core_out;

endpackage

`default_nettype wire

// ===== rtl/core/cbd_if.sv =====
// Channel interfaces: tape bit input and deframed result output.
`default_nettype none

interface cbd_bit_if;
    logic valid;
    logic ready;
    logic bit_in;

    modport source (output valid, output bit_in, input ready);
    modport sink   (input valid, input bit_in, output ready);
endinterface

interface cbd_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] hdr_type;
    logic [7:0] hdr_len;
    logic       checksum_bad;
    logic       last;

    modport source (
        output valid, output kind, output data_byte, output byte_index,
        output hdr_type, output hdr_len, output checksum_bad, output last,
        input  ready
    );
    modport sink (
        input  valid, input kind, input data_byte, input byte_index,
        input  hdr_type, input hdr_len, input checksum_bad, input last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/cbd_in_stage.sv =====
// Input register for tape bit beats.
`default_nettype none

module cbd_in_stage (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbd_bit_if.sink   i_bits,
    input  wire logic i_take,
    output logic      o_valid,
    output logic      o_bit
);

    logic r_valid;
    logic r_bit;

    // Refill in the same cycle the held beat moves on.
    assign i_bits.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_bits.valid && i_bits.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bits.valid && i_bits.ready) begin
            r_bit <= i_bits.bit_in;
        end
    end

    assign o_valid = r_valid;
    assign o_bit   = r_bit;

endmodule

`default_nettype wire

// ===== rtl/core/cbd_core.sv =====
// Sync hunt, byte assembly, block field capture and checksum tracking.
`default_nettype none
`include "cassette_block_deframer_macros.svh"

module cbd_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_advance,
    input  wire logic        i_bit,
    output cbd_pkg::t_core_out o_core
);

    cbd_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_sync;
    logic [7:0] r_hunt, n_hunt;
    logic [cbd_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0] r_asm, n_asm;
    logic [7:0] r_type, n_type;
    logic [7:0] r_len, n_len;
    logic [7:0] r_pcount, n_pcount;
    logic [7:0] r_sum, n_sum;

    logic [7:0] shifted_asm;
    logic [7:0] next_pcount;
    logic       byte_done;

    assign shifted_asm = {i_bit, r_asm[7:1]};
    assign next_pcount = r_pcount + 8'd1;
    assign byte_done   = (r_cnt == cbd_pkg::CNT_LAST);

    always_comb begin
        n_phase  = r_phase;
        n_hunt   = r_hunt;
        n_cnt    = r_cnt;
        n_asm    = r_asm;
        n_type   = r_type;
        n_len    = r_len;
        n_pcount = r_pcount;
        n_sum    = r_sum;
        o_core   = '0;

        case (r_phase)
            cbd_pkg::PH_TYPE, cbd_pkg::PH_LEN, cbd_pkg::PH_DATA, cbd_pkg::PH_SUM: begin
                n_asm = shifted_asm;
                n_cnt = r_cnt + 1'b1;
                if (byte_done) begin
                    // start the next byte from a cleared assembly
                    n_asm = '0;
                    n_cnt = '0;
                    case (r_phase)
                        cbd_pkg::PH_TYPE: begin
                            n_type  = shifted_asm;
                            n_phase = cbd_pkg::PH_LEN;
                        end
                        cbd_pkg::PH_LEN: begin
                            n_len    = shifted_asm;
                            n_sum    = r_type + shifted_asm;
                            n_pcount = '0;
                            n_phase  = (shifted_asm == 8'd0) ? cbd_pkg::PH_SUM
                                                             : cbd_pkg::PH_DATA;
                        end
                        cbd_pkg::PH_DATA: begin
                            o_core.valid            = 1'b1;
                            o_core.res.kind         = cbd_pkg::KIND_DATA;
                            o_core.res.data_byte    = shifted_asm;
                            o_core.res.byte_index   = r_pcount;
                            o_core.res.hdr_type     = r_type;
                            o_core.res.hdr_len      = r_len;
                            n_sum    = r_sum + shifted_asm;
                            n_pcount = next_pcount;
                            n_phase  = (next_pcount == r_len) ? cbd_pkg::PH_SUM
                                                              : cbd_pkg::PH_DATA;
                        end
                        default: begin
                            o_core.valid            = 1'b1;
                            o_core.res.kind         = cbd_pkg::KIND_END;
                            o_core.res.hdr_type     = r_type;
                            o_core.res.hdr_len      = r_len;
                            o_core.res.checksum_bad = (r_sum != shifted_asm);
                            o_core.res.last         = 1'b1;
                            n_hunt  = '0;
                            n_phase = cbd_pkg::PH_HUNT;
                        end
                    endcase
                end
            end
            default: begin
                // hunt: shift in at the top, compare after every bit
                n_hunt = {i_bit, r_hunt[7:1]};
                if (n_hunt == r_sync) begin
                    n_phase = cbd_pkg::PH_TYPE;
                    n_cnt   = '0;
                    n_asm   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= cbd_pkg::SYNC_RESET;
        end else if (i_cfg_wr_en) begin
            r_sync <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cbd_pkg::PH_HUNT;
            r_hunt   <= '0;
            r_cnt    <= '0;
            r_asm    <= '0;
            r_type   <= '0;
            r_len    <= '0;
            r_pcount <= '0;
            r_sum    <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_hunt   <= n_hunt;
            r_cnt    <= n_cnt;
            r_asm    <= n_asm;
            r_type   <= n_type;
            r_len    <= n_len;
            r_pcount <= n_pcount;
            r_sum    <= n_sum;
        end
    end

    `CBD_ASSERT_SAME(a_result_on_byte_end, i_clk, i_rst_n, o_core.valid,
        byte_done && (r_phase == cbd_pkg::PH_DATA || r_phase == cbd_pkg::PH_SUM),
        "result outside a completed data or checksum byte")
    `CBD_ASSERT_NEXT(a_hunt_after_end, i_clk, i_rst_n,
        i_advance && o_core.valid && o_core.res.last,
        r_phase == cbd_pkg::PH_HUNT && r_hunt == 8'd0,
        "hunt did not restart after end of block")
    `CBD_ASSERT_SAME(a_index_in_range, i_clk, i_rst_n,
        r_phase == cbd_pkg::PH_DATA, r_pcount < r_len,
        "payload count reached length inside data phase")
    `CBD_ASSERT_SAME(a_hunt_clean_asm, i_clk, i_rst_n,
        r_phase == cbd_pkg::PH_HUNT, r_cnt == '0 && r_asm == 8'd0,
        "byte assembly not cleared while hunting")

endmodule

`default_nettype wire

// ===== rtl/core/cbd_out_stage.sv =====
// Result register between the deframer core and the result channel.
`default_nettype none

module cbd_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cbd_pkg::t_core_out i_core,
    input  wire logic               i_advance,
    output logic                    o_can_load,
    cbd_res_if.source               o_res
);

    logic             r_valid;
    cbd_pkg::t_result r_res;
    logic             load;

    assign o_can_load = !r_valid || o_res.ready;
    assign load       = i_advance && i_core.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= load;
        end
    end

    // hold the payload until the beat is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_core.res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.data_byte    = r_res.data_byte;
    assign o_res.byte_index   = r_res.byte_index;
    assign o_res.hdr_type     = r_res.hdr_type;
    assign o_res.hdr_len      = r_res.hdr_len;
    assign o_res.checksum_bad = r_res.checksum_bad;
    assign o_res.last         = r_res.last;

endmodule

`default_nettype wire

// ===== rtl/core/cassette_block_deframer.sv =====
// Cassette block deframer: bit stream in, payload bytes and end-of-block status out.
//
// Usage:
//   i_bits carries one decoded tape bit per beat, least significant bit of
//   each byte first. o_res carries one beat per payload byte (kind 0, with
//   its index) and one end beat per block (kind 1, last 1) with type,
//   length and a flag for a wrapping-sum checksum mismatch.
//   i_cfg_wr_en / i_cfg_wr_data load the sync byte; write only while idle.
// Path: an accepted bit waits in the input register, then the state update
//   processes it, and a result that it ends is loaded into the result register.
// Throughput: one bit per cycle while o_res is not held off; the input
//   register, the state update and the result register pass a beat every cycle.
// Reset: sync byte returns to 0x3c, the block hunts from a cleared shift
//   register, both registers empty.
// Stall: when o_res is held off, the result register keeps its beat, state
//   update pauses, and i_bits.ready drops once the input register is full.
`default_nettype none

module cassette_block_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    cbd_bit_if.sink         i_bits,
    cbd_res_if.source       o_res
);

    logic               in_valid;
    logic               in_bit;
    logic               can_load;
    logic               advance;
    cbd_pkg::t_core_out core_out;

    assign advance = in_valid && can_load;

    cbd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bits  (i_bits),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_bit   (in_bit)
    );

    cbd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_advance     (advance),
        .i_bit         (in_bit),
        .o_core        (core_out)
    );

    cbd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_core     (core_out),
        .i_advance  (advance),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the cassette block deframer: framed bit streams in, checked beats out.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic       sink_ready = 1'b0;

    cbd_bit_if bits_if ();
    cbd_res_if res_if ();

    assign res_if.ready = sink_ready;

    cassette_block_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_bits        (bits_if),
        .o_res         (res_if)
    );

    // Deframer state as the testbench sees it
    logic [7:0]      sync_byte   = cbd_pkg::SYNC_RESET;
    logic [7:0]      tape_shift  = '0;
    cbd_pkg::t_phase frame_phase = cbd_pkg::PH_HUNT;
    logic [2:0]      bit_pos     = '0;
    logic [7:0]      byte_acc    = '0;
    logic [7:0]      blk_type    = '0;
    logic [7:0]      blk_len     = '0;
    logic [7:0]      pay_count   = '0;
    logic [7:0]      run_sum     = '0;

    cbd_pkg::t_result due_results[$];

    int  mismatches   = 0;
    int  bits_sent    = 0;
    int  cycle_count  = 0;
    int  hold_left    = 0;
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;
    cbd_pkg::t_result got_res;
    cbd_pkg::t_result want_res;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("tb: mismatch on %s: got %02h, expected %02h", what, got, want);
    endtask

    // Advance the deframer state by one accepted bit; queue any result it produces.
    task automatic deframe_bit(input logic b);
        cbd_pkg::t_result r;
        logic [7:0]       done;
        if (frame_phase == cbd_pkg::PH_HUNT) begin
            tape_shift = {b, tape_shift[7:1]};
            if (tape_shift == sync_byte) begin
                frame_phase = cbd_pkg::PH_TYPE;
                bit_pos = '0;
                byte_acc = '0;
            end
        end else begin
            byte_acc = {b, byte_acc[7:1]};
            bit_pos = bit_pos + 3'd1;
            if (bit_pos == 3'd0) begin
                done = byte_acc;
                byte_acc = '0;
                r = '0;
                r.hdr_type = blk_type;
                r.hdr_len = blk_len;
                case (frame_phase)
                    cbd_pkg::PH_TYPE: begin
                        blk_type = done;
                        frame_phase = cbd_pkg::PH_LEN;
                    end
                    cbd_pkg::PH_LEN: begin
                        blk_len = done;
                        run_sum = blk_type + done;
                        pay_count = '0;
                        frame_phase = (done == 8'd0) ? cbd_pkg::PH_SUM : cbd_pkg::PH_DATA;
                    end
                    cbd_pkg::PH_DATA: begin
                        r.kind = cbd_pkg::KIND_DATA;
                        r.data_byte = done;
                        r.byte_index = pay_count;
                        due_results.push_back(r);
                        run_sum = run_sum + done;
                        pay_count = pay_count + 8'd1;
                        if (pay_count == blk_len)
                            frame_phase = cbd_pkg::PH_SUM;
                    end
                    default: begin
                        r.kind = cbd_pkg::KIND_END;
                        r.checksum_bad = (run_sum != done);
                        r.last = 1'b1;
                        due_results.push_back(r);
                        tape_shift = '0;
                        frame_phase = cbd_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    endtask

    task automatic send_bit(input logic b);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            bits_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        bits_if.valid <= 1'b1;
        bits_if.bit_in <= b;
        @(posedge i_clk);
        while (!bits_if.ready) @(posedge i_clk);
        deframe_bit(b);
        bits_sent++;
    endtask

    task automatic send_byte(input logic [7:0] v);
        for (int i = 0; i < 8; i++)
            send_bit(v[i]);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_bit(1'($urandom_range(0, 1)));
    endtask

    // Finish whatever frame is open; zeros keep a half-built length byte short.
    task automatic drain_frame();
        while (frame_phase != cbd_pkg::PH_HUNT) begin
            if (frame_phase == cbd_pkg::PH_TYPE || frame_phase == cbd_pkg::PH_LEN)
                send_bit(1'b0);
            else
                send_bit(1'($urandom_range(0, 1)));
        end
    endtask

    // Stop early when the hunt register already matches.
    task automatic send_sync();
        for (int i = 0; i < 8 && frame_phase == cbd_pkg::PH_HUNT; i++)
            send_bit(sync_byte[i]);
    endtask

    // fill < 0 gives random payload; cut stops the frame at a random bit.
    task automatic send_frame(input logic [7:0] typ, input logic [7:0] len,
                              input bit bad, input bit cut, input int fill);
        logic [7:0] body[$];
        logic [7:0] sum;
        int         stop;
        body = {typ, len};
        sum = typ + len;
        for (int i = 0; i < len; i++) begin
            body.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
            sum = sum + body[$];
        end
        if (bad)
            sum = sum ^ 8'($urandom_range(1, 255));
        body.push_back(sum);
        drain_frame();
        send_sync();
        stop = cut ? $urandom_range(1, body.size() * 8 - 1) : body.size() * 8;
        for (int i = 0; i < stop; i++)
            send_bit(body[i / 8][i % 8]);
    endtask

    // Hold the sender until every result is in and the pipeline is empty.
    task automatic settle();
        bits_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sync_byte = v;
    endtask

    task automatic test_default_sync();
        send_frame(8'h00, 8'h00, 1'b0, 1'b0, -1);
        send_frame(8'hff, 8'h00, 1'b1, 1'b0, -1);
        send_frame(8'hff, 8'h01, 1'b1, 1'b0, 8'hff);
        send_frame(8'h80, 8'h03, 1'b0, 1'b0, 8'h00);
    endtask

    task automatic test_sync_extremes();
        write_sync(8'h00);
        send_frame(8'h01, 8'h02, 1'b0, 1'b0, -1);
        send_noise(5);
        send_frame(8'h00, 8'h00, 1'b1, 1'b0, -1);
        write_sync(8'hff);
        send_noise(7);
        send_frame(8'hfe, 8'h04, 1'b0, 1'b0, 8'hff);
        send_frame(8'h3c, 8'h01, 1'b1, 1'b0, 8'h00);
    endtask

    // A new sync byte written mid-block only matters once hunting resumes.
    task automatic test_sync_change_midblock();
        write_sync(8'h3c);
        drain_frame();
        send_sync();
        send_byte(8'h11);
        send_byte(8'h02);
        send_byte(8'h5a);
        write_sync(8'ha5);
        send_byte(8'h33);
        send_byte(8'h11 + 8'h02 + 8'h5a + 8'h33);
        send_frame(8'h22, 8'h01, 1'b0, 1'b0, -1);
        send_noise(3);
        write_sync(8'h96);
        send_frame(8'h44, 8'h02, 1'b1, 1'b0, -1);
    endtask

    // Length with the top bit set; the index walks past 8'h7f.
    task automatic test_long_frame();
        send_frame(8'h7f, 8'h81, 1'b0, 1'b0, -1);
    endtask

    task automatic test_random_traffic(input int n);
        int target;
        int frames;
        target = bits_sent + n;
        frames = 0;
        while (bits_sent < target) begin
            if (frames % 12 == 11) begin
                case ($urandom_range(0, 3))
                    0: write_sync(8'h00);
                    1: write_sync(8'hff);
                    default: write_sync(8'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                src_idle_on = ~src_idle_on;
            if ($urandom_range(0, 7) == 0)
                sink_idle_on = ~sink_idle_on;
            if ($urandom_range(0, 1) == 0)
                send_noise($urandom_range(1, 12));
            send_frame(8'($urandom_range(0, 255)),
                       ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 40))
                                                   : 8'($urandom_range(0, 8)),
                       $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0, -1);
            frames++;
        end
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_quiet_tail();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        write_sync(8'h5c);
        repeat (4)
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
                       $urandom_range(0, 1) == 1, 1'b0, -1);
        drain_frame();
    endtask

    // Check each result beat against the oldest expectation; drive ready stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got_res.kind = res_if.kind;
                got_res.data_byte = res_if.data_byte;
                got_res.byte_index = res_if.byte_index;
                got_res.hdr_type = res_if.hdr_type;
                got_res.hdr_len = res_if.hdr_len;
                got_res.checksum_bad = res_if.checksum_bad;
                got_res.last = res_if.last;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected beat, kind", 8'(got_res.kind), 8'h00);
                end else begin
                    want_res = due_results.pop_front();
                    if (got_res.kind !== want_res.kind)
                        report_mismatch("kind", 8'(got_res.kind), 8'(want_res.kind));
                    if (got_res.data_byte !== want_res.data_byte)
                        report_mismatch("data_byte", got_res.data_byte, want_res.data_byte);
                    if (got_res.byte_index !== want_res.byte_index)
                        report_mismatch("byte_index", got_res.byte_index, want_res.byte_index);
                    if (got_res.hdr_type !== want_res.hdr_type)
                        report_mismatch("hdr_type", got_res.hdr_type, want_res.hdr_type);
                    if (got_res.hdr_len !== want_res.hdr_len)
                        report_mismatch("hdr_len", got_res.hdr_len, want_res.hdr_len);
                    if (got_res.checksum_bad !== want_res.checksum_bad)
                        report_mismatch("checksum_bad", 8'(got_res.checksum_bad),
                                        8'(want_res.checksum_bad));
                    if (got_res.last !== want_res.last)
                        report_mismatch("last", 8'(got_res.last), 8'(want_res.last));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                sink_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                hold_left <= $urandom_range(0, 16);
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        bits_if.valid <= 1'b0;
        bits_if.bit_in <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_sync();
        test_sync_extremes();
        test_sync_change_midblock();
        test_long_frame();
        test_random_traffic(100);
        test_quiet_tail();

        bits_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
